// ===== sv/lge_pkg.sv =====
`timescale 1ns / 1ps
// lge_pkg: grid dimensions, item structs, codes and RAM request type
// shared by every module of the life generation engine; no dependencies

package lge_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int ColW = $clog2(GRID_WIDTH);
  localparam int RowW = $clog2(GRID_HEIGHT);
  localparam int PadW = $clog2(GRID_WIDTH + 2);

  localparam int BirthCount  = 3;
  localparam int SurviveLow  = 2;
  localparam int SurviveHigh = 3;

  typedef logic [GRID_WIDTH-1:0] row_t;
  typedef logic [ColW-1:0]       col_t;
  typedef logic [RowW-1:0]       row_addr_t;
  typedef logic [PadW-1:0]       pad_t;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_READ    = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    TR_STAYED_ALIVE = 2'd0,
    TR_BORN         = 2'd1,
    TR_DIED         = 2'd2,
    TR_STAYED_DEAD  = 2'd3
  } transition_e;

  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_value;
  } lge_in_t;

  typedef struct packed {
    logic       result_kind;
    logic       cell_state;
    logic [1:0] transition_code;
  } lge_out_t;

  typedef struct packed {
    logic      re;
    logic      we;
    row_addr_t addr;
    row_t      wmask;
    row_t      wdata;
  } ram_req_t;

endpackage

// ===== sv/life_generation_engine.sv =====
`timescale 1ns / 1ps
// life_generation_engine: top level, sequencer, row window and result register
// depends on lge_pkg, lge_row_ram and lge_cell_unit
//
// Usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) takes write, advance and
//   read items; out channel (out_valid_o / out_ready_i / out_data_o) returns
//   one result for each advance or read item, none for write or unused codes.
//   A write goes to both grids as it is accepted. A read item moves to a
//   response state that loads its result into the result register once
//   that register is free. An advance item sweeps the grid one cell per
//   cycle through a single neighbor-count unit; after each row a write-back
//   state writes the new row and shifts the three-row window.
//   in_ready_o is high only while no item is at work. After reset a clearing
//   pass writes every row of both grids dead; no item is accepted during it.
//   The result register holds its item while the receiver stalls; a new item
//   is still accepted, and one that has a result waits until the register
//   frees up.

module life_generation_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lge_pkg::lge_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lge_pkg::lge_out_t out_data_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_RESP,
    ST_ADV_RD0,
    ST_ADV_RD1,
    ST_ADV_RD2,
    ST_ADV_CELL,
    ST_ADV_ROW,
    ST_ADV_DONE
  } state_e;

  state_e             state_q;
  lge_pkg::col_t      x_q;
  lge_pkg::row_addr_t y_q;
  lge_pkg::row_t      above_q;
  lge_pkg::row_t      mid_q;
  lge_pkg::row_t      below_q;
  lge_pkg::row_t      newrow_q;
  lge_pkg::col_t      rx_q;
  logic               rin_q;
  logic               out_valid_q;
  lge_pkg::lge_out_t  out_data_q;

  lge_pkg::ram_req_t  cur_req;
  lge_pkg::ram_req_t  prev_req;
  lge_pkg::row_t      cur_rd;
  lge_pkg::row_t      prev_rd;
  logic               cell_next;

  logic               in_accept;
  logic               in_inside;
  lge_pkg::col_t      in_col;
  lge_pkg::row_addr_t in_row;
  lge_pkg::row_t      in_mask;
  logic               out_free;
  logic               out_load;
  logic               more_rows;
  logic               last_col;
  logic               last_row;
  logic               rd_now;
  logic               rd_before;
  lge_pkg::transition_e rd_code;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_inside  = (int'(in_data_i.cell_x) < lge_pkg::GRID_WIDTH)
                   && (int'(in_data_i.cell_y) < lge_pkg::GRID_HEIGHT);
  assign in_col     = lge_pkg::col_t'(in_data_i.cell_x);
  assign in_row     = lge_pkg::row_addr_t'(in_data_i.cell_y);
  assign in_mask    = lge_pkg::row_t'(1) << in_col;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = out_free && (state_q == ST_RD_RESP || state_q == ST_ADV_DONE);
  assign more_rows  = (int'(y_q) + 2 < lge_pkg::GRID_HEIGHT);
  assign last_col   = (int'(x_q) == lge_pkg::GRID_WIDTH - 1);
  assign last_row   = (int'(y_q) == lge_pkg::GRID_HEIGHT - 1);

  assign rd_now    = rin_q && cur_rd[rx_q];
  assign rd_before = rin_q && prev_rd[rx_q];

  always_comb begin
    priority if (rd_before && rd_now) begin
      rd_code = lge_pkg::TR_STAYED_ALIVE;
    end else if (rd_now) begin
      rd_code = lge_pkg::TR_BORN;
    end else if (rd_before) begin
      rd_code = lge_pkg::TR_DIED;
    end else begin
      rd_code = lge_pkg::TR_STAYED_DEAD;
    end
  end

  always_comb begin
    cur_req  = '0;
    prev_req = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cur_req.we     = 1'b1;
        cur_req.addr   = y_q;
        cur_req.wmask  = '1;
        prev_req.we    = 1'b1;
        prev_req.addr  = y_q;
        prev_req.wmask = '1;
      end
      ST_IDLE: begin
        if (in_accept && in_inside && in_data_i.action == lge_pkg::ACT_WRITE) begin
          cur_req.we     = 1'b1;
          cur_req.addr   = in_row;
          cur_req.wmask  = in_mask;
          cur_req.wdata  = in_data_i.cell_value ? in_mask : '0;
          prev_req.we    = 1'b1;
          prev_req.addr  = in_row;
          prev_req.wmask = in_mask;
          prev_req.wdata = in_data_i.cell_value ? in_mask : '0;
        end
        if (in_accept && in_data_i.action == lge_pkg::ACT_READ) begin
          cur_req.re    = 1'b1;
          cur_req.addr  = in_row;
          prev_req.re   = 1'b1;
          prev_req.addr = in_row;
        end
      end
      ST_ADV_RD0: begin
        cur_req.re   = 1'b1;
        cur_req.addr = lge_pkg::row_addr_t'(0);
      end
      ST_ADV_RD1: begin
        cur_req.re   = 1'b1;
        cur_req.addr = lge_pkg::row_addr_t'(1);
      end
      ST_ADV_CELL: begin
        if (x_q == '0 && more_rows) begin
          cur_req.re   = 1'b1;
          cur_req.addr = y_q + lge_pkg::row_addr_t'(2);
        end
      end
      ST_ADV_ROW: begin
        cur_req.we     = 1'b1;
        cur_req.addr   = y_q;
        cur_req.wmask  = '1;
        cur_req.wdata  = newrow_q;
        prev_req.we    = 1'b1;
        prev_req.addr  = y_q;
        prev_req.wmask = '1;
        prev_req.wdata = mid_q;
      end
      default: begin
      end
    endcase
  end

  lge_row_ram u_cur_ram (
    .clk_i     (clk_i),
    .req_i     (cur_req),
    .rd_data_o (cur_rd)
  );

  lge_row_ram u_prev_ram (
    .clk_i     (clk_i),
    .req_i     (prev_req),
    .rd_data_o (prev_rd)
  );

  lge_cell_unit u_cell (
    .above_i (above_q),
    .mid_i   (mid_q),
    .below_i (below_q),
    .col_i   (x_q),
    .alive_o (cell_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      x_q         <= '0;
      y_q         <= '0;
      above_q     <= '0;
      mid_q       <= '0;
      below_q     <= '0;
      newrow_q    <= '0;
      rx_q        <= '0;
      rin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (last_row) begin
            y_q     <= '0;
            state_q <= ST_IDLE;
          end else begin
            y_q <= y_q + lge_pkg::row_addr_t'(1);
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            rx_q  <= in_col;
            rin_q <= in_inside;
            if (in_data_i.action == lge_pkg::ACT_ADVANCE) begin
              state_q <= ST_ADV_RD0;
            end else if (in_data_i.action == lge_pkg::ACT_READ) begin
              state_q <= ST_RD_RESP;
            end
          end
        end
        ST_RD_RESP: begin
          if (out_free) begin
            out_data_q.result_kind     <= lge_pkg::KIND_READ;
            out_data_q.cell_state      <= rd_now;
            out_data_q.transition_code <= rd_code;
            state_q                    <= ST_IDLE;
          end
        end
        ST_ADV_RD0: begin
          above_q <= '0;
          state_q <= ST_ADV_RD1;
        end
        ST_ADV_RD1: begin
          mid_q   <= cur_rd;
          state_q <= ST_ADV_RD2;
        end
        ST_ADV_RD2: begin
          below_q <= cur_rd;
          x_q     <= '0;
          y_q     <= '0;
          state_q <= ST_ADV_CELL;
        end
        ST_ADV_CELL: begin
          newrow_q[x_q] <= cell_next;
          if (last_col) begin
            state_q <= ST_ADV_ROW;
          end else begin
            x_q <= x_q + lge_pkg::col_t'(1);
          end
        end
        ST_ADV_ROW: begin
          above_q <= mid_q;
          mid_q   <= below_q;
          below_q <= more_rows ? cur_rd : '0;
          x_q     <= '0;
          if (last_row) begin
            y_q     <= '0;
            state_q <= ST_ADV_DONE;
          end else begin
            y_q     <= y_q + lge_pkg::row_addr_t'(1);
            state_q <= ST_ADV_CELL;
          end
        end
        ST_ADV_DONE: begin
          if (out_free) begin
            out_data_q.result_kind     <= lge_pkg::KIND_DONE;
            out_data_q.cell_state      <= 1'b0;
            out_data_q.transition_code <= lge_pkg::TR_STAYED_ALIVE;
            state_q                    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // both grids always see the same row written together
  a_paired_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_req.we |-> (prev_req.we && prev_req.addr == cur_req.addr))
    else $error("current and previous grid writes diverge");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cur_req.re && cur_req.we))
    else $error("current grid read and written in the same cycle");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_RD_RESP || $past(state_q) == ST_ADV_DONE))
    else $error("result appeared outside a response state");

  a_sweep_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV_ROW) |-> ($past(state_q) == ST_ADV_CELL && last_col))
    else $error("row written back before its last cell");

endmodule

// ===== sv/lge_row_ram.sv =====
`timescale 1ns / 1ps
// lge_row_ram: one grid stored as rows of cells, bit-masked write port
// and one registered read port; depends on lge_pkg

module lge_row_ram (
  input  logic              clk_i,
  input  lge_pkg::ram_req_t req_i,
  output lge_pkg::row_t     rd_data_o
);

  lge_pkg::row_t mem [lge_pkg::GRID_HEIGHT];
  lge_pkg::row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int i = 0; i < lge_pkg::GRID_WIDTH; i++) begin
        if (req_i.wmask[i]) begin
          mem[req_i.addr][i] <= req_i.wdata[i];
        end
      end
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/lge_cell_unit.sv =====
`timescale 1ns / 1ps
// lge_cell_unit: neighbor count and birth/survival rule for one cell,
// taken from a three-row window; depends on lge_pkg

module lge_cell_unit (
  input  lge_pkg::row_t above_i,
  input  lge_pkg::row_t mid_i,
  input  lge_pkg::row_t below_i,
  input  lge_pkg::col_t col_i,
  output logic          alive_o
);

  logic [lge_pkg::GRID_WIDTH+1:0] pad_above;
  logic [lge_pkg::GRID_WIDTH+1:0] pad_mid;
  logic [lge_pkg::GRID_WIDTH+1:0] pad_below;
  lge_pkg::pad_t                  idx_w;
  lge_pkg::pad_t                  idx_c;
  lge_pkg::pad_t                  idx_e;
  logic [3:0]                     count;
  logic                           self;

  // zero pads stand for the dead cells beyond the west and east edges
  assign pad_above = {1'b0, above_i, 1'b0};
  assign pad_mid   = {1'b0, mid_i, 1'b0};
  assign pad_below = {1'b0, below_i, 1'b0};

  assign idx_w = lge_pkg::pad_t'(col_i);
  assign idx_c = idx_w + lge_pkg::pad_t'(1);
  assign idx_e = idx_w + lge_pkg::pad_t'(2);

  assign self = pad_mid[idx_c];

  always_comb begin
    count = 4'(pad_above[idx_w]) + 4'(pad_above[idx_c]) + 4'(pad_above[idx_e])
          + 4'(pad_mid[idx_w]) + 4'(pad_mid[idx_e])
          + 4'(pad_below[idx_w]) + 4'(pad_below[idx_c]) + 4'(pad_below[idx_e]);
    if (self) begin
      alive_o = (int'(count) >= lge_pkg::SurviveLow) && (int'(count) <= lge_pkg::SurviveHigh);
    end else begin
      alive_o = (int'(count) == lge_pkg::BirthCount);
    end
  end

endmodule
